FILE: sv/ffba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and codes of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned SIZE_W = 16;
  localparam int unsigned HDR_W  = 7;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BADREL  = 2'd3;

  // config register indexes
  localparam logic CFG_ARENA  = 1'b0;
  localparam logic CFG_HEADER = 1'b1;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [3:0] {
    S_INIT,     // clear table to one free block
    S_IDLE,
    S_SCAN,     // read entry at scan index
    S_EVAL,     // evaluate read data
    S_SHUP,     // shift entries up by one (split)
    S_SPLIT,    // write split pair
    S_RD_NB,    // read neighbors
    S_MERGE,    // decide merges
    S_SHDN,     // shift entries down (remove)
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic init;
    logic start;      // latch input word, reset scan index
    logic scan_rd;    // issue read at scan index
    logic scan_inc;
    logic alloc_mark; // mark found block used (no split)
    logic shup_step;
    logic split_wr;
    logic free_mark;
    logic nb_rd;
    logic merge_step; // compute merge and set remove index
    logic shdn_step;
    logic set_status;
    logic [1:0] status;
    logic out_load;
  } ffba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_alloc;
    logic scan_end;
    logic hit;       // entry matches search
    logic need_split;
    logic full;
    logic used_hit;  // release target currently in use
    logic shup_done;
    logic shdn_done;
    logic merge_more; // another merge pending
    logic merge_last; // left-neighbor check (or later) under way
    logic out_busy;
  } ffba_sts_t;

endpackage
`default_nettype wire

FILE: sv/ffba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer for scan, split shift and merge shift of the block table.
// ----------------------------------------------------------------------------
module ffba_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              init_req,
  input  wire logic              in_fire,
  output logic                   in_rdy,
  input  wire ffba_pkg::ffba_sts_t sts,
  output ffba_pkg::ffba_cmd_t    cmd
);

  ffba_pkg::state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffba_pkg::S_INIT:  state_nxt = ffba_pkg::S_IDLE;
      ffba_pkg::S_IDLE:  if (init_req) state_nxt = ffba_pkg::S_INIT;
                         else if (in_fire) state_nxt = ffba_pkg::S_SCAN;
      ffba_pkg::S_SCAN:  state_nxt = sts.scan_end ? ffba_pkg::S_DONE : ffba_pkg::S_EVAL;
      ffba_pkg::S_EVAL: begin
        if (!sts.hit) state_nxt = ffba_pkg::S_SCAN;
        else if (sts.is_alloc) begin
          if (!sts.need_split) state_nxt = ffba_pkg::S_DONE;
          else if (sts.full) state_nxt = ffba_pkg::S_DONE;
          else state_nxt = ffba_pkg::S_SHUP;
        end else if (!sts.used_hit) state_nxt = ffba_pkg::S_DONE;
        else state_nxt = ffba_pkg::S_RD_NB;
      end
      ffba_pkg::S_SHUP:  if (sts.shup_done) state_nxt = ffba_pkg::S_SPLIT;
      ffba_pkg::S_SPLIT: state_nxt = ffba_pkg::S_DONE;
      ffba_pkg::S_RD_NB: state_nxt = ffba_pkg::S_MERGE;
      ffba_pkg::S_MERGE: begin
        // no right merge: go on to the left-neighbor check
        if (sts.merge_more) state_nxt = ffba_pkg::S_SHDN;
        else if (sts.merge_last) state_nxt = ffba_pkg::S_DONE;
        else state_nxt = ffba_pkg::S_MERGE;
      end
      ffba_pkg::S_SHDN:  if (sts.shdn_done) state_nxt = ffba_pkg::S_RD_NB;
      ffba_pkg::S_DONE:  if (!sts.out_busy) state_nxt = ffba_pkg::S_IDLE;
      default:           state_nxt = ffba_pkg::S_INIT;
    endcase
  end

  // outputs
  always_comb begin
    cmd    = '0;
    in_rdy = 1'b0;
    case (state_r)
      ffba_pkg::S_INIT: cmd.init = 1'b1;
      ffba_pkg::S_IDLE: begin
        in_rdy    = !init_req;
        cmd.start = in_fire;
      end
      ffba_pkg::S_SCAN: begin
        cmd.scan_rd = !sts.scan_end;
        if (sts.scan_end) begin
          cmd.set_status = 1'b1;
          cmd.status = sts.is_alloc ? ffba_pkg::ST_NOFIT : ffba_pkg::ST_BADREL;
        end
      end
      ffba_pkg::S_EVAL: begin
        cmd.scan_inc = !sts.hit;
        if (sts.hit) begin
          cmd.set_status = 1'b1;
          if (sts.is_alloc) begin
            cmd.status = (sts.need_split && sts.full) ? ffba_pkg::ST_FULL : ffba_pkg::ST_OK;
            cmd.alloc_mark = !sts.need_split;
          end else begin
            cmd.status = sts.used_hit ? ffba_pkg::ST_OK : ffba_pkg::ST_BADREL;
            cmd.free_mark = sts.used_hit;
          end
        end
      end
      ffba_pkg::S_SHUP:  cmd.shup_step = 1'b1;
      ffba_pkg::S_SPLIT: cmd.split_wr = 1'b1;
      ffba_pkg::S_RD_NB: cmd.nb_rd = 1'b1;
      ffba_pkg::S_MERGE: cmd.merge_step = 1'b1;
      ffba_pkg::S_SHDN:  cmd.shdn_step = 1'b1;
      ffba_pkg::S_DONE:  cmd.out_load = !sts.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ffba_pkg::S_INIT;
    else state_r <= state_nxt;
  end

endmodule
`default_nettype wire

FILE: sv/ffba_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_dp
// Block table memory, scan index, split/merge arithmetic and result register.
// ----------------------------------------------------------------------------
module ffba_dp #(
  parameter int unsigned MAX_BLOCKS = 64,
  parameter int unsigned ADDR_BITS  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ffba_pkg::ffba_cmd_t cmd,
  output ffba_pkg::ffba_sts_t    sts,
  input  wire logic [ffba_pkg::SIZE_W-1:0] arena_size,
  input  wire logic [ffba_pkg::HDR_W-1:0]  header_size,
  input  wire logic              in_kind,
  input  wire logic [ffba_pkg::SIZE_W-1:0] in_req,
  input  wire logic [ffba_pkg::SIZE_W-1:0] in_rel,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_status,
  output logic [ffba_pkg::SIZE_W-1:0] out_offset
);

  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned AW = ADDR_BITS;
  localparam int unsigned EW = 2 * AW + 1;
  localparam logic [CW-1:0] CMAX = CW'(MAX_BLOCKS);

  // table entry: {free, length, start}
  logic [EW-1:0] mem [MAX_BLOCKS];
  logic [EW-1:0] rd_r, rd2_r;
  logic [EW-1:0] shd_r;     // entry in transit during a shift

  logic [CW-1:0] count_r, idx_r, sh_r;
  logic          kind_r;
  logic [ffba_pkg::SIZE_W-1:0] req_r, rel_r;
  logic [1:0]    status_r;
  logic [ffba_pkg::SIZE_W-1:0] offset_r;
  logic          ov_r;
  logic [1:0]    mphase_r; // 0 right merge pending, 1 left merge, 2 done
  logic [AW-1:0] acc_len_r;

  logic [AW-1:0] hdr, reqa, relA;
  logic [AW-1:0] rstart, rlen;
  logic          rfree;
  logic [AW:0]   need;
  logic [AW-1:0] init_len;
  logic [AW-1:0] rmerge_len;

  assign hdr  = AW'(header_size);
  assign reqa = AW'(req_r);
  assign relA = AW'(rel_r);
  assign rstart = rd_r[AW-1:0];
  assign rlen   = rd_r[2*AW-1:AW];
  assign rfree  = rd_r[EW-1];
  assign need   = {1'b0, reqa} + {1'b0, hdr};
  assign init_len = (AW'(arena_size) > hdr) ? AW'(arena_size) - hdr : '0;
  assign rmerge_len = AW'(hdr + acc_len_r + rd2_r[2*AW-1:AW]);

  // status to controller
  always_comb begin
    sts = '0;
    sts.is_alloc  = (kind_r == ffba_pkg::KIND_ALLOC);
    sts.scan_end  = (idx_r >= count_r) || (sts.is_alloc && req_r == '0);
    sts.hit       = sts.is_alloc ? (rfree && rlen >= reqa)
                                 : (AW'(rstart + hdr) == relA);
    sts.need_split = {1'b0, rlen} > need;
    sts.full      = (count_r >= CMAX);
    sts.used_hit  = !rfree;
    sts.shup_done = (sh_r <= idx_r + CW'(1));
    sts.shdn_done = (sh_r + CW'(1) >= count_r);
    sts.out_busy  = ov_r && !out_ready;
    sts.merge_last = (mphase_r != 2'd0);
    // merge pending if the checked neighbor pair is both free
    sts.merge_more = 1'b0;
    if (mphase_r == 2'd0)
      sts.merge_more = (idx_r + CW'(1) < count_r) && rd2_r[EW-1];
    else if (mphase_r == 2'd1)
      sts.merge_more = (idx_r != '0) && rd_r[EW-1];
  end

  // table memory; shifts move each entry through shd_r
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      mem[0] <= {1'b1, init_len, {AW{1'b0}}};
    end
    if (cmd.scan_rd) rd_r <= mem[idx_r[IW-1:0]];
    if (cmd.alloc_mark) mem[idx_r[IW-1:0]] <= {1'b0, rlen, rstart};
    if (cmd.free_mark) begin
      mem[idx_r[IW-1:0]] <= {1'b1, rlen, rstart};
      acc_len_r <= rlen;
    end
    // prefetch the top entry ahead of a split shift
    if (cmd.set_status && sts.need_split && !sts.full)
      shd_r <= mem[IW'(count_r - CW'(1))];
    if (cmd.shup_step) begin
      mem[sh_r[IW-1:0]] <= shd_r;
      shd_r <= mem[IW'(sh_r - CW'(2))];
    end
    if (cmd.split_wr) begin
      mem[idx_r[IW-1:0]] <= {1'b0, reqa, rstart};
      mem[IW'(idx_r + CW'(1))] <= {1'b1, AW'(rlen - hdr - reqa),
                                   AW'(rstart + hdr + reqa)};
    end
    if (cmd.nb_rd) begin
      // rd_r: left neighbor, rd2_r: right neighbor
      if (idx_r != '0) rd_r <= mem[IW'(idx_r - CW'(1))];
      else rd_r <= '0;
      if (idx_r + CW'(1) < count_r) rd2_r <= mem[IW'(idx_r + CW'(1))];
      else rd2_r <= '0;
    end
    if (cmd.merge_step && sts.merge_more) begin
      if (mphase_r == 2'd0) begin
        // block start is the release offset minus one header
        mem[idx_r[IW-1:0]] <= {1'b1, rmerge_len, AW'(relA - hdr)};
        acc_len_r <= rmerge_len;
        shd_r <= mem[IW'(idx_r + CW'(2))];
      end else begin
        mem[IW'(idx_r - CW'(1))] <= {1'b1, AW'(hdr + rd_r[2*AW-1:AW] + acc_len_r),
                                     rd_r[AW-1:0]};
        shd_r <= mem[IW'(idx_r + CW'(1))];
      end
    end
    if (cmd.shdn_step) begin
      mem[sh_r[IW-1:0]] <= shd_r;
      shd_r <= mem[IW'(sh_r + CW'(2))];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CW'(1);
      ov_r <= 1'b0;
      idx_r <= '0;
      sh_r <= '0;
      mphase_r <= '0;
    end else begin
      if (cmd.init) count_r <= CW'(1);
      if (cmd.start) begin
        idx_r <= '0;
        kind_r <= in_kind;
        req_r <= in_req;
        rel_r <= in_rel;
        offset_r <= '0;
        mphase_r <= 2'd0;
      end
      if (cmd.scan_inc) idx_r <= idx_r + CW'(1);
      if (cmd.set_status) status_r <= cmd.status;
      if (cmd.set_status && cmd.status == ffba_pkg::ST_OK && kind_r == ffba_pkg::KIND_ALLOC)
        offset_r <= ffba_pkg::SIZE_W'(AW'(rstart + hdr));
      if (cmd.set_status && sts.need_split && !sts.full) sh_r <= count_r;
      if (cmd.shup_step && !sts.shup_done) sh_r <= sh_r - CW'(1);
      if (cmd.split_wr) count_r <= count_r + CW'(1);
      if (cmd.merge_step) begin
        if (sts.merge_more) begin
          // remove entry right of the merged block
          sh_r <= (mphase_r == 2'd0) ? idx_r + CW'(1) : idx_r;
          if (mphase_r == 2'd1) idx_r <= idx_r - CW'(1);
        end
        mphase_r <= mphase_r + 2'd1;
      end
      if (cmd.shdn_step) begin
        if (sts.shdn_done) count_r <= count_r - CW'(1);
        else sh_r <= sh_r + CW'(1);
      end
      if (cmd.out_load) ov_r <= 1'b1;
      else if (ov_r && out_ready) ov_r <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= status_r;
      out_offset <= offset_r;
    end
  end

  assign out_valid = ov_r;

endmodule
`default_nettype wire

FILE: sv/first_fit_block_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A request takes longer the further its scan runs, and longer again for each entry
// moved on a split or on a merge shift.
// Throughput: one word at a time; the table memory port sets the pace.
// Reset: synchronous, active low; it re-creates one free block, as
// does any config write.
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit arena allocator with split and coalescing release.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS = 64,
  parameter int unsigned ADDR_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // request_size[15:0], release_offset[31:16]
  input  wire logic        s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // status[1:0], payload_offset[17:2], zero pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  ffba_pkg::ffba_cmd_t cmd;
  ffba_pkg::ffba_sts_t sts;
  logic [15:0] arena_r;
  logic [6:0]  hdr_r;
  logic        init_r;
  logic        in_rdy;
  logic [1:0]  st;
  logic [15:0] off;

  assign cfg_ready = 1'b1;

  // config registers; a write requests table reinit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_r <= 16'd4096;
      hdr_r   <= 7'd32;
      init_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == ffba_pkg::CFG_ARENA) arena_r <= cfg_data;
        else hdr_r <= cfg_data[6:0];
        init_r <= 1'b1;
      end else if (cmd.init) init_r <= 1'b0;
    end
  end

  assign s_axis_tready = in_rdy;

  ffba_ctrl u_ctrl (
    .clk, .rst_n,
    .init_req (init_r),
    .in_fire  (s_axis_tvalid && in_rdy),
    .in_rdy,
    .sts, .cmd
  );

  ffba_dp #(.MAX_BLOCKS(MAX_BLOCKS), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .arena_size  (arena_r),
    .header_size (hdr_r),
    .in_kind     (s_axis_tuser),
    .in_req      (s_axis_tdata[15:0]),
    .in_rel      (s_axis_tdata[31:16]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_status  (st),
    .out_offset  (off)
  );

  assign m_axis_tdata = {6'd0, off, st};

endmodule
`default_nettype wire

FILE: sim/ffba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_checker
// Watches the request, grant and register channels of the allocator, keeps
// its own block table, predicts every grant word and compares it with the
// word the block returns.
// ----------------------------------------------------------------------------
module ffba_checker #(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [31:0] in_data,   // request_size[15:0], release_offset[31:16]
  input  wire logic        in_kind,   // kind
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [23:0] out_data,  // status[1:0], payload_offset[17:2], zero pad
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               errors,
  output int               pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] offset;
  } grant_t;

  grant_t grant_q[$];

  // shadow of the block table
  int unsigned arena_bytes;
  int unsigned hdr_bytes;
  int unsigned blk_start[MAX_BLOCKS];
  int unsigned blk_len[MAX_BLOCKS];
  bit          blk_free[MAX_BLOCKS];
  int unsigned blk_cnt;

  task automatic rebuild_table();
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      blk_start[k] = 0;
      blk_len[k]   = 0;
      blk_free[k]  = 0;
    end
    blk_len[0]  = (arena_bytes > hdr_bytes) ? ((arena_bytes - hdr_bytes) & 16'hFFFF) : 0;
    blk_free[0] = 1;
    blk_cnt     = 1;
  endtask

  // drop entry idx, moving later entries down
  task automatic drop_entry(input int unsigned idx);
    for (int unsigned k = idx; k + 1 < blk_cnt; k++) begin
      blk_start[k] = blk_start[k+1];
      blk_len[k]   = blk_len[k+1];
      blk_free[k]  = blk_free[k+1];
    end
    blk_cnt--;
  endtask

  task automatic join_next(input int unsigned idx);
    blk_len[idx] = (hdr_bytes + blk_len[idx] + blk_len[idx+1]) & 16'hFFFF;
    drop_entry(idx + 1);
  endtask

  task automatic grant_alloc(input int unsigned req, output grant_t g);
    int unsigned idx;
    bit found;
    found = 0;
    idx = 0;
    g = '{status: ffba_pkg::ST_OK, offset: 16'd0};
    if (req != 0) begin
      for (int unsigned k = 0; k < blk_cnt && !found; k++) begin
        if (blk_free[k] && blk_len[k] >= req) begin
          found = 1;
          idx = k;
        end
      end
    end
    if (!found) begin
      g.status = ffba_pkg::ST_NOFIT;
    end else if (blk_len[idx] > req + hdr_bytes) begin
      if (blk_cnt >= MAX_BLOCKS) begin
        g.status = ffba_pkg::ST_FULL;
      end else begin
        for (int unsigned k = blk_cnt; k > idx + 1; k--) begin
          blk_start[k] = blk_start[k-1];
          blk_len[k]   = blk_len[k-1];
          blk_free[k]  = blk_free[k-1];
        end
        blk_start[idx+1] = (blk_start[idx] + hdr_bytes + req) & 16'hFFFF;
        blk_len[idx+1]   = (blk_len[idx] - hdr_bytes - req) & 16'hFFFF;
        blk_free[idx+1]  = 1;
        blk_cnt++;
        blk_len[idx]  = req;
        blk_free[idx] = 0;
        g.offset = 16'(blk_start[idx] + hdr_bytes);
      end
    end else begin
      blk_free[idx] = 0;
      g.offset = 16'(blk_start[idx] + hdr_bytes);
    end
  endtask

  task automatic grant_release(input int unsigned rel, output grant_t g);
    int unsigned idx;
    bit found;
    found = 0;
    idx = 0;
    g = '{status: ffba_pkg::ST_OK, offset: 16'd0};
    for (int unsigned k = 0; k < blk_cnt && !found; k++) begin
      if (((blk_start[k] + hdr_bytes) & 16'hFFFF) == rel) begin
        found = 1;
        idx = k;
      end
    end
    if (!found || blk_free[idx]) begin
      g.status = ffba_pkg::ST_BADREL;
    end else begin
      blk_free[idx] = 1;
      if (idx + 1 < blk_cnt && blk_free[idx+1]) join_next(idx);
      if (idx > 0 && blk_free[idx-1]) join_next(idx - 1);
    end
  endtask

  // sample all three channels at the edge
  always @(posedge clk) begin
    grant_t g;
    grant_t got;
    if (!rst_n) begin
      arena_bytes = 4096;
      hdr_bytes   = 32;
      rebuild_table();
      grant_q.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ffba_pkg::CFG_ARENA) arena_bytes = cfg_data;
        else hdr_bytes = cfg_data & 16'h7F;
        rebuild_table();
      end
      if (in_valid && in_ready) begin
        if (in_kind == ffba_pkg::KIND_ALLOC) grant_alloc(in_data[15:0], g);
        else grant_release(in_data[31:16], g);
        grant_q.push_back(g);
      end
      if (out_valid && out_ready) begin
        got = '{status: out_data[1:0], offset: out_data[17:2]};
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected grant word status=%0d offset=%0d",
                   $time, got.status, got.offset);
          errors <= errors + 1;
        end else begin
          g = grant_q.pop_front();
          if (got.status !== g.status || got.offset !== g.offset ||
              out_data[23:18] !== 6'd0) begin
            $display("%0t: mismatch expected status=%0d offset=%0d",
                     $time, g.status, g.offset);
            $display("%0t:          actual status=%0d offset=%0d pad=%0h",
                     $time, got.status, got.offset, out_data[23:18]);
            errors <= errors + 1;
          end
        end
      end
      pending <= grant_q.size();
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and release requests into the first-fit allocator under
// several arena and header settings, with bursty input and a stalling
// output; the checker predicts and compares every grant word.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_data;   // request_size[15:0], release_offset[31:16]
  logic        in_kind;   // kind
  logic        out_valid;
  logic        out_ready;
  logic [23:0] out_data;  // status[1:0], payload_offset[17:2], zero pad
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;
  int          errors;
  int          pending;

  logic [15:0] live_q[$];  // payload offsets currently granted
  int          sent;
  int          phases;
  bit          hold_req;
  int          quiet;

  first_fit_block_allocator_top u_top (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(in_valid), .s_axis_tready(in_ready),
    .s_axis_tdata(in_data), .s_axis_tuser(in_kind),
    .m_axis_tvalid(out_valid), .m_axis_tready(out_ready), .m_axis_tdata(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ffba_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data), .in_kind(in_kind),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // clock
  initial clk = 0;
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // remember granted offsets so releases hit live blocks
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready && out_data[17:2] != 0)
      live_q.push_back(out_data[17:2]);
  end

  // receiver: stall pattern plus one long hold-off
  initial begin
    int mode;
    int span;
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 0;
        repeat (2500) @(posedge clk);
        hold_req = 0;
      end
      mode = $urandom_range(2);
      span = $urandom_range(1, 100);
      repeat (span) begin
        if (hold_req) break;
        case (mode)
          0: out_ready <= 1;
          1: out_ready <= 1'($urandom_range(1));
          default: out_ready <= ($urandom_range(4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no accepted word
  initial begin
    quiet = 0;
    while (quiet < LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_word(input logic kind, input logic [15:0] req, input logic [15:0] rel);
    in_kind  <= kind;
    in_data  <= {rel, req};
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // let the last accepted word reach the pending count before checking it
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    drain();
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    live_q.delete();
    phases++;
    @(posedge clk);
  endtask

  task automatic random_word();
    int r;
    int p;
    logic [15:0] sz;
    r = $urandom_range(99);
    if (r < 55) begin
      p = $urandom_range(9);
      if (p < 4) sz = 16'($urandom_range(1, 16));
      else if (p < 8) sz = 16'($urandom_range(1, 400));
      else if (p < 9) sz = 16'($urandom_range(0, 4000));
      else sz = 16'($urandom);
      send_word(ffba_pkg::KIND_ALLOC, sz, 16'($urandom));
    end else if (r < 92 && live_q.size() > 0) begin
      p = $urandom_range(live_q.size() - 1);
      sz = live_q[p];
      live_q.delete(p);
      send_word(ffba_pkg::KIND_RELEASE, 16'($urandom), sz);
    end else begin
      send_word(1'($urandom_range(1)), 16'($urandom), 16'($urandom));
    end
  endtask

  // bursts of random words with random gaps
  task automatic random_phase(input int count, input bit pressure);
    int left;
    int burst;
    int gap;
    bit drained;
    left = count;
    drained = 0;
    while (left > 0) begin
      if (pressure && left <= count / 2) begin
        hold_req = 1;
        pressure = 0;
      end
      if (!drained && left <= count / 3) begin
        drain();
        drained = 1;
      end
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        if (left > 0) begin
          random_word();
          left--;
        end
      end
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 0;
  endtask

  initial begin
    in_valid  = 0;
    in_data   = 0;
    in_kind   = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data  = 0;
    hold_req  = 0;
    sent      = 0;
    phases    = 1;
    rst_n     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: default arena 4096, header 32
    send_word(ffba_pkg::KIND_ALLOC, 16'd0, 16'hFFFF);      // zero size
    send_word(ffba_pkg::KIND_ALLOC, 16'hFFFF, 16'd0);      // no fit
    send_word(ffba_pkg::KIND_ALLOC, 16'd4064, 16'd0);      // exact fit, whole arena
    send_word(ffba_pkg::KIND_RELEASE, 16'd0, 16'd32);      // release it
    send_word(ffba_pkg::KIND_RELEASE, 16'hFFFF, 16'd32);   // release of a free block
    send_word(ffba_pkg::KIND_RELEASE, 16'd0, 16'd0);       // unknown offset
    send_word(ffba_pkg::KIND_RELEASE, 16'd0, 16'hFFFF);    // unknown offset
    send_word(ffba_pkg::KIND_ALLOC, 16'd4032, 16'd0);      // excess of one header, no split
    send_word(ffba_pkg::KIND_RELEASE, 16'd0, 16'd32);
    send_word(ffba_pkg::KIND_ALLOC, 16'd100, 16'd0);       // 32
    send_word(ffba_pkg::KIND_ALLOC, 16'd200, 16'd0);       // 164
    send_word(ffba_pkg::KIND_ALLOC, 16'd300, 16'd0);       // 396
    send_word(ffba_pkg::KIND_ALLOC, 16'd1, 16'd0);         // 728
    send_word(ffba_pkg::KIND_RELEASE, 16'd0, 16'd164);     // middle, no merge
    send_word(ffba_pkg::KIND_RELEASE, 16'd0, 16'd32);      // merges right
    send_word(ffba_pkg::KIND_RELEASE, 16'd0, 16'd396);     // merges left
    send_word(ffba_pkg::KIND_RELEASE, 16'd0, 16'd728);     // merges both sides
    send_word(ffba_pkg::KIND_ALLOC, 16'd4065, 16'd0);      // one too many
    in_valid <= 0;
    live_q.delete();

    random_phase(350, 1);
    write_reg(ffba_pkg::CFG_HEADER, 16'd8);
    random_phase(300, 0);
    write_reg(ffba_pkg::CFG_ARENA, 16'hFFFF);
    random_phase(250, 0);
    write_reg(ffba_pkg::CFG_HEADER, 16'd64);
    write_reg(ffba_pkg::CFG_ARENA, 16'd64);                 // arena equals header
    send_word(ffba_pkg::KIND_ALLOC, 16'd1, 16'd0);
    send_word(ffba_pkg::KIND_RELEASE, 16'd0, 16'd64);
    random_phase(40, 0);
    write_reg(ffba_pkg::CFG_HEADER, 16'd8);
    random_phase(150, 0);
    write_reg(ffba_pkg::CFG_ARENA, 16'd1000);
    write_reg(ffba_pkg::CFG_HEADER, 16'd64);
    random_phase(250, 0);
    write_reg(ffba_pkg::CFG_ARENA, 16'($urandom_range(64, 65535)));
    write_reg(ffba_pkg::CFG_HEADER, 16'($urandom_range(8, 64)));
    random_phase(300, 0);
    drain();

    $display("Covered %0d request words over %0d register settings,", sent, phases);
    $display("with bursty input, output stalls and one long output hold-off.");
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
